// ----- hw/rtl/fcd_pkg.sv -----
// Package with the FNV-1a constants, opcode type and hash step shared by the detector.
`timescale 1ns / 1ps

package fcd_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_FORCE = 1'b1
    } opcode_t;

    // The prime is 2^24 + 2^8 + 0x93, so the product is a sum of six shifted copies.
    // The sum wraps modulo 2^32, as the hash requires.
    function automatic logic [31:0] fnv_mul(input logic [31:0] h);
        return (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    endfunction

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        return fnv_mul(h ^ {24'd0, b});
    endfunction

endpackage

// ----- hw/rtl/frame_change_detector_unit.sv -----
// Frame change detector: FNV-1a hash over a byte stream with a flush decision per frame.
`timescale 1ns / 1ps
// A word accepted on s_ passes the input register, then the hash and compare step into
// the result register, before its result shows on m_.
// Throughput: one word per cycle while m_ is not blocked, carried by the hash feedback
// through the shift-add multiplier. Only words with tuser = 0 and tlast = 1 give a result.
// Reset (aresetn low, synchronous) empties both registers, loads the offset basis into
// the running hash, clears the stored hash and sets the force flag.

module frame_change_detector_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] frame_byte
    input  logic                  s_tlast,   // last_byte
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] frame_hash
    output logic                  m_tuser    // [0] flush
);
    import fcd_pkg::*;

    logic        in_valid_reg;
    opcode_t     in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic [31:0] running_hash_reg, running_hash_next;
    logic [31:0] last_flushed_hash_reg, last_flushed_hash_next;
    logic        force_pending_reg, force_pending_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_flush_reg, out_flush_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic        advance;
    logic        out_load;
    logic [31:0] hash_step;
    logic        flush_now;

    // The stage advances when the result register is free or being emptied.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign hash_step = fnv_step(running_hash_reg, in_byte_reg);
    assign flush_now = force_pending_reg || (hash_step != last_flushed_hash_reg);
    assign out_load  = in_valid_reg && advance && (in_op_reg == OP_FRAME) && in_last_reg;

    always_comb begin
        running_hash_next      = running_hash_reg;
        last_flushed_hash_next = last_flushed_hash_reg;
        force_pending_next     = force_pending_reg;
        out_valid_next         = out_valid_reg && !m_tready;
        out_flush_next         = out_flush_reg;
        out_hash_next          = out_hash_reg;
        if (in_valid_reg && advance) begin
            case (in_op_reg)
                OP_FORCE: begin
                    force_pending_next = 1'b1;
                end
                OP_FRAME: begin
                    if (in_last_reg) begin
                        running_hash_next = FNV_BASIS;
                        out_valid_next    = 1'b1;
                        out_flush_next    = flush_now;
                        out_hash_next     = hash_step;
                        if (flush_now) begin
                            last_flushed_hash_next = hash_step;
                            force_pending_next     = 1'b0;
                        end
                    end else begin
                        running_hash_next = hash_step;
                    end
                end
                default: begin
                    force_pending_next = force_pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            running_hash_reg      <= FNV_BASIS;
            last_flushed_hash_reg <= 32'd0;
            force_pending_reg     <= 1'b1;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg         <= out_valid_next;
            running_hash_reg      <= running_hash_next;
            last_flushed_hash_reg <= last_flushed_hash_next;
            force_pending_reg     <= force_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= opcode_t'(s_tuser);
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_flush_reg <= out_flush_next;
        out_hash_reg  <= out_hash_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flush_reg;
    assign m_tdata  = out_hash_reg;

    // Every completed frame restarts the hash at the offset basis.
    a_restart_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> running_hash_reg == FNV_BASIS)
        else $error("running hash not restarted after a frame");

    // A flush consumes any pending force request.
    a_flush_clears_force: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && flush_now |=> !force_pending_reg)
        else $error("force flag still set after a flush");

    // A skipped frame must match the hash of the frame last sent.
    a_skip_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == last_flushed_hash_reg)
        else $error("skipped frame hash differs from stored hash");

    // Input stalls only when both registers hold a word and the output is blocked.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

endmodule
